// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, switched off while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ps2mpc_pkg.sv -----
// ---------------------------------------------------------------------------
// ps2mpc_pkg
// Types and constants of the PS/2 mouse packet and cursor block.
// ---------------------------------------------------------------------------
package ps2mpc_pkg;

  // Header byte bit positions
  localparam int unsigned LB_BIT    = 0;
  localparam int unsigned RB_BIT    = 1;
  localparam int unsigned MB_BIT    = 2;
  localparam int unsigned SYNC_BIT  = 3;
  localparam int unsigned XSIGN_BIT = 4;
  localparam int unsigned YSIGN_BIT = 5;
  localparam int unsigned XOV_BIT   = 6;
  localparam int unsigned YOV_BIT   = 7;

  localparam int unsigned COORD_W  = 11;
  localparam int unsigned MOVE_W   = 9;
  localparam int unsigned SUM_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 2'd1;

  localparam logic [COORD_W-1:0] X_LIMIT_RST  = 11'd800;
  localparam logic [COORD_W-1:0] Y_LIMIT_RST  = 11'd600;
  localparam logic [COORD_W-1:0] POSITION_RST = 11'd10;

  // Byte position within a packet
  typedef enum logic [2:0] {
    POS_HEADER = 3'b001,
    POS_SECOND = 3'b010,
    POS_THIRD  = 3'b100
  } pos_t;

endpackage

// ----- hw/rtl/ps2_mouse_packet_cursor.sv -----
// ---------------------------------------------------------------------------
// ps2_mouse_packet_cursor
// PS/2 three-byte packet parser with a clamped cursor position.
// ---------------------------------------------------------------------------
// Mouse bytes enter on the slave stream, tuser set marking a failed read.
// A failed read drops the byte and restarts the packet; a header byte
// without bit 3 set is dropped. On the third byte the cursor moves: X adds
// the movement, Y subtracts it, each clamped to 0..limit, and an axis whose
// overflow flag is set keeps its position. One result request then carries
// the packet fields and the new position. The block takes one byte per
// clock cycle while intake is not paused; an accepted byte passes the input
// register, then parse and clamp logic into the result register. Intake
// pauses only while a finished result is held by the master side and the
// byte at the input register would make another. The user must write limits
// through the cfg port only while the block is idle; the block itself does
// not enforce it. Index 0 is x_limit, index 1 is y_limit, other indexes are
// ignored. Cursor starts at (10, 10); limits reset to 800 and 600.
`include "assert_macros.svh"

module ps2_mouse_packet_cursor (
  input  logic                              clk,
  input  logic                              rst,
  // slave stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
  input  logic                              s_axis_tuser,  // [0] read_error
  // master stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] left_button, [1] right_button, [2] middle_button, [11:3] move_x,
  // [20:12] move_y, [21] x_overflowed, [22] y_overflowed,
  // [33:23] cursor_x, [44:34] cursor_y, [47:45] zero
  output logic [47:0]                       m_axis_tdata,
  // configuration write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ps2mpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ps2mpc_pkg::COORD_W-1:0]    cfg_data
);

  import ps2mpc_pkg::*;

  // Clamp pos + delta to 0..limit
  function automatic logic [COORD_W-1:0] clamp_move(
    input logic [COORD_W-1:0] pos_in,
    input logic [SUM_W-1:0]   delta,
    input logic [COORD_W-1:0] limit
  );
    logic [SUM_W-1:0] sum;
    logic [COORD_W-1:0] res;
    sum = {2'b00, pos_in} + delta;
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (sum[SUM_W-2:0] > {1'b0, limit}) begin
      res = limit;
    end else begin
      res = sum[COORD_W-1:0];
    end
    return res;
  endfunction

  // Configuration registers
  logic [COORD_W-1:0] x_limit;
  logic [COORD_W-1:0] y_limit;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_err;

  // Packet state
  pos_t               pos;
  pos_t               pos_next;
  logic [7:0]         header_byte;
  logic [7:0]         second_byte;
  logic [COORD_W-1:0] position_x;
  logic [COORD_W-1:0] position_y;

  // Result register
  logic               out_valid;
  logic               out_lb;
  logic               out_rb;
  logic               out_mb;
  logic [MOVE_W-1:0]  out_move_x;
  logic [MOVE_W-1:0]  out_move_y;
  logic               out_xov;
  logic               out_yov;
  logic [COORD_W-1:0] out_cx;
  logic [COORD_W-1:0] out_cy;

  logic               produce;
  logic               hdr_load;
  logic               sec_load;
  logic               advance;
  logic [MOVE_W-1:0]  move_x;
  logic [MOVE_W-1:0]  move_y;
  logic [SUM_W-1:0]   delta_x;
  logic [SUM_W-1:0]   delta_y;
  logic [COORD_W-1:0] position_x_next;
  logic [COORD_W-1:0] position_y_next;

  assign cfg_ready = 1'b1;

  // Decode the byte held in the input register
  always_comb begin
    pos_next = pos;
    produce  = 1'b0;
    hdr_load = 1'b0;
    sec_load = 1'b0;
    if (in_err) begin
      pos_next = POS_HEADER;
    end else begin
      unique case (pos)
        POS_SECOND: begin
          sec_load = 1'b1;
          pos_next = POS_THIRD;
        end
        POS_THIRD: begin
          produce  = 1'b1;
          pos_next = POS_HEADER;
        end
        default: begin
          // drop a header byte without sync
          if (in_byte[SYNC_BIT]) begin
            hdr_load = 1'b1;
            pos_next = POS_SECOND;
          end else begin
            pos_next = POS_HEADER;
          end
        end
      endcase
    end
  end

  // Movement and clamped position; Y grows downward, so subtract dy
  assign move_x  = {header_byte[XSIGN_BIT], second_byte};
  assign move_y  = {header_byte[YSIGN_BIT], in_byte};
  assign delta_x = {{(SUM_W-MOVE_W){move_x[MOVE_W-1]}}, move_x};
  assign delta_y = SUM_W'(0) - {{(SUM_W-MOVE_W){move_y[MOVE_W-1]}}, move_y};

  assign position_x_next = header_byte[XOV_BIT] ? position_x
                                                : clamp_move(position_x, delta_x, x_limit);
  assign position_y_next = header_byte[YOV_BIT] ? position_y
                                                : clamp_move(position_y, delta_y, y_limit);

  // Hold the input byte only when it makes a result and the result slot is full and not taken
  assign advance       = in_valid && (!produce || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_err  <= s_axis_tuser;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit <= X_LIMIT_RST;
      y_limit <= Y_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_X_LIMIT: x_limit <= cfg_data;
        CFG_Y_LIMIT: y_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Packet state and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_HEADER;
      header_byte <= '0;
      second_byte <= '0;
      position_x  <= POSITION_RST;
      position_y  <= POSITION_RST;
    end else if (advance) begin
      pos <= pos_next;
      if (hdr_load) begin
        header_byte <= in_byte;
      end
      if (sec_load) begin
        second_byte <= in_byte;
      end
      if (produce) begin
        position_x <= position_x_next;
        position_y <= position_y_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      out_lb     <= header_byte[LB_BIT];
      out_rb     <= header_byte[RB_BIT];
      out_mb     <= header_byte[MB_BIT];
      out_move_x <= move_x;
      out_move_y <= move_y;
      out_xov    <= header_byte[XOV_BIT];
      out_yov    <= header_byte[YOV_BIT];
      out_cx     <= position_x_next;
      out_cy     <= position_y_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_cy, out_cx, out_yov, out_xov,
                          out_move_y, out_move_x, out_mb, out_rb, out_lb};

  // Assertions
  `ASSERT_CLK(a_no_result_after_reset, clk, rst |=> !out_valid, "result valid after reset")
  `ASSERT_CLKD(a_err_restarts, clk, rst, advance && in_err |=> pos == POS_HEADER,
               "read error did not restart the packet")
  `ASSERT_CLKD(a_result_loaded, clk, rst, advance && produce |=> out_valid,
               "third byte gave no result")
  `ASSERT_CLKD(a_stall_cause, clk, rst,
               in_valid && !advance |-> out_valid && !m_axis_tready && produce,
               "input held without a blocked result")

endmodule
